[rtl/lockstep_round_robin_scheduler_macros.svh]
// assertion macros for the lock-step round-robin scheduler
`ifndef LOCKSTEP_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define LOCKSTEP_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define LRRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lrrs assertion failed");
`define LRRS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lrrs assertion failed");
`else
`define LRRS_ASSERT(lbl, clk, rst, prop)
`define LRRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/lrrs_pkg.sv]
package lrrs_pkg;

   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_BARRIER = 2'd2;
   localparam logic [1:0] FUNC_SELECT  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] state_id;
      logic        has_parent;
      logic [15:0] parent_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] selected_id;
      logic [31:0] state_time;
      logic        round_done;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        blocked;
      logic        skip;
      logic [15:0] id;
   } entry_type;

endpackage

[rtl/lrrs_table.sv]
module lrrs_table
   import lrrs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lrrs_ctrl.sv]
`include "lockstep_round_robin_scheduler_macros.svh"

module lrrs_ctrl
   import lrrs_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int AW          = 6,
   parameter int CW          = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req,
   output logic          busy,
   input  logic [15:0]   step_inc,
   output logic          rsp_valid,
   output rsp_type       rsp,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output entry_type     mem_wr_data,
   output logic [AW-1:0] mem_rd_addr,
   input  entry_type     mem_rd_data
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CLR     = 4'd1;
   localparam logic [3:0] S_FIND_RD = 4'd2;
   localparam logic [3:0] S_FIND_EX = 4'd3;
   localparam logic [3:0] S_ADD_WR  = 4'd4;
   localparam logic [3:0] S_UNB_RD  = 4'd5;
   localparam logic [3:0] S_UNB_EX  = 4'd6;
   localparam logic [3:0] S_SCAN_RD = 4'd7;
   localparam logic [3:0] S_SCAN_EX = 4'd8;
   localparam logic [3:0] S_CMP_RD  = 4'd9;
   localparam logic [3:0] S_CMP_EX  = 4'd10;
   localparam logic [3:0] S_CMP_CLR = 4'd11;

   localparam logic [CW-1:0] CNT_ONE  = CW'(1);
   localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_DEPTH - 1);

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] tail_ff, tail_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] hole_ff, hole_in;
   logic [CW-1:0] bcnt_ff, bcnt_in;
   logic [31:0]   time_ff, time_in;
   req_type       req_ff, req_in;
   logic          round_ff, round_in;
   logic          blk_ff, blk_in;
   logic          skp_ff, skp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [15:0]   key;
   logic [CW-1:0] live;
   entry_type     rd;

   assign key  = (req_ff.func == FUNC_ADD) ? req_ff.parent_id : req_ff.state_id;
   assign live = tail_ff - hole_ff;
   assign rd   = mem_rd_data;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wr_ptr_in    = wr_ptr_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      hole_in      = hole_ff;
      bcnt_in      = bcnt_ff;
      time_in      = time_ff;
      req_in       = req_ff;
      round_in     = round_ff;
      blk_in       = blk_ff;
      skp_in       = skp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff[AW-1:0];
      mem_wr_data  = rd;
      mem_rd_addr  = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               round_in = 1'b0;
               blk_in   = 1'b0;
               skp_in   = 1'b0;
               idx_in   = '0;
               rsp_in   = '0;
               case (req.func)
                  FUNC_ADD: begin
                     if (tail_ff >= CNT_FULL) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (req.has_parent) begin
                        state_in = S_FIND_RD;
                     end else begin
                        state_in = S_ADD_WR;
                     end
                  end
                  FUNC_REMOVE, FUNC_BARRIER: begin
                     state_in = S_FIND_RD;
                  end
                  default: begin
                     if (hole_ff > tail_ff || live == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (live == bcnt_ff) begin
                        state_in = S_UNB_RD;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
               endcase
            end
         end
         S_CLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            idx_in      = idx_ff + CNT_ONE;
            if (idx_ff == CNT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_FIND_RD: begin
            if (idx_ff >= tail_ff) begin
               rsp_in.status = STATUS_NOT_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_FIND_EX;
            end
         end
         S_FIND_EX: begin
            if (rd.valid && rd.id == key) begin
               case (req_ff.func)
                  FUNC_ADD: begin
                     blk_in   = rd.blocked;
                     skp_in   = idx_ff < ptr_ff;
                     state_in = S_ADD_WR;
                  end
                  FUNC_REMOVE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{valid: 1'b0, blocked: 1'b0, skip: 1'b0, id: rd.id};
                     hole_in     = hole_ff + CNT_ONE;
                     if (rd.blocked && bcnt_ff != '0) begin
                        bcnt_in = bcnt_ff - CNT_ONE;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
                  default: begin
                     if (!rd.blocked) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data.blocked = 1'b1;
                        bcnt_in             = bcnt_ff + CNT_ONE;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + CNT_ONE;
               state_in = S_FIND_RD;
            end
         end
         S_ADD_WR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = tail_ff[AW-1:0];
            mem_wr_data  = '{valid: 1'b1, blocked: blk_ff, skip: skp_ff,
                             id: req_ff.state_id};
            tail_in      = tail_ff + CNT_ONE;
            if (blk_ff) begin
               bcnt_in = bcnt_ff + CNT_ONE;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_UNB_RD: begin
            if (idx_ff >= tail_ff) begin
               bcnt_in  = '0;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_UNB_EX;
            end
         end
         S_UNB_EX: begin
            mem_wr_en           = 1'b1;
            mem_wr_data.blocked = 1'b0;
            idx_in              = idx_ff + CNT_ONE;
            state_in            = S_UNB_RD;
         end
         S_SCAN_RD: begin
            mem_rd_addr = ptr_ff[AW-1:0];
            if (ptr_ff >= tail_ff) begin
               idx_in    = '0;
               wr_ptr_in = '0;
               state_in  = S_CMP_RD;
            end else begin
               state_in = S_SCAN_EX;
            end
         end
         S_SCAN_EX: begin
            ptr_in   = ptr_ff + CNT_ONE;
            state_in = S_SCAN_RD;
            if (!rd.valid || rd.skip) begin
               mem_wr_en        = 1'b1;
               mem_wr_addr      = ptr_ff[AW-1:0];
               mem_wr_data.skip = 1'b0;
            end else if (!rd.blocked) begin
               rsp_in.selected_id = rd.id;
               rsp_in.state_time  = time_ff;
               rsp_in.round_done  = round_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_CMP_RD: begin
            if (idx_ff >= tail_ff) begin
               idx_in   = wr_ptr_ff;
               state_in = S_CMP_CLR;
            end else begin
               state_in = S_CMP_EX;
            end
         end
         S_CMP_EX: begin
            if (rd.valid) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ptr_ff[AW-1:0];
               wr_ptr_in   = wr_ptr_ff + CNT_ONE;
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = S_CMP_RD;
         end
         S_CMP_CLR: begin
            if (idx_ff >= tail_ff) begin
               tail_in  = wr_ptr_ff;
               hole_in  = '0;
               ptr_in   = '0;
               time_in  = time_ff + {16'd0, step_inc};
               round_in = 1'b1;
               state_in = S_SCAN_RD;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = '0;
               idx_in      = idx_ff + CNT_ONE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         idx_ff       <= '0;
         tail_ff      <= '0;
         ptr_ff       <= '0;
         hole_ff      <= '0;
         bcnt_ff      <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tail_ff      <= tail_in;
         ptr_ff       <= ptr_in;
         hole_ff      <= hole_in;
         bcnt_ff      <= bcnt_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff <= wr_ptr_in;
      req_ff    <= req_in;
      round_ff  <= round_in;
      blk_ff    <= blk_in;
      skp_ff    <= skp_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `LRRS_ASSERT(a_rsp_idle, clock, reset, rsp_valid_ff |-> !busy)
   `LRRS_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> (busy || rsp_valid_ff))
   `LRRS_ASSERT(a_holes_le_tail, clock, reset, hole_ff <= tail_ff)
   `LRRS_ASSERT(a_blocked_le_live, clock, reset, bcnt_ff <= tail_ff - hole_ff)

endmodule

[rtl/lockstep_round_robin_scheduler.sv]
// add without parent goes straight to its write; a lookup reads, then examines, each slot
//   searched; select reads and examines each slot scanned, after unblocking all slots
//   if all live entries are blocked; a round wrap compacts the table first
// after reset a clearing pass over all TABLE_DEPTH entries runs with busy high
// one transaction at a time; the response strobe lasts one cycle, no stall
module lockstep_round_robin_scheduler
   import lrrs_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [15:0]   step_ff;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 16'd1;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   lrrs_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lrrs_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .busy        (busy),
      .step_inc    (step_ff),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
